@@ design/qrr_pkg.sv @@
// Shared constants and the pipeline word of the quaternion relative rotation unit.
// No dependencies.
package qrr_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int VALUE_WIDTH    = 32;

    // fraction bits in use, capped as the arithmetic allows
    localparam int QF = (QUAT_FRAC_BITS > 30) ? 30 : QUAT_FRAC_BITS;
    // effective clamp width of the value difference
    localparam int VW_EFF = (VALUE_WIDTH < 2) ? 2 : ((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32);

    localparam int QW   = 16;           // quaternion component width
    localparam int NW   = 33;           // squared norm / product magnitude width
    localparam int SW   = 34;           // signed product sum width
    localparam int RW   = 34 + QF + 16; // divider remainder width
    localparam int DIV_STAGES = 8;      // two quotient bits per stage
    localparam int QBITS = 2 * DIV_STAGES;

    localparam logic CMD_QUAT  = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    typedef struct packed {
        logic                       valid;
        logic                       cmd;
        logic [2:0]                 channel;
        logic [31:0]                vdiff;
        logic                       vsat;
        logic                       nz;
        logic [RW-1:0]              den;
        logic [3:0]                 neg;
        logic [3:0]                 big;
        logic [3:0][RW-1:0]         rem;
        logic [3:0][QBITS-1:0]      quo;
    } t_div_word;

endpackage

@@ design/qrr_front.sv @@
// Front of the pipeline: products, sums and divider set-up, three register stages.
// Depends on qrr_pkg.
module qrr_front import qrr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic signed [15:0] i_a [4],
    input  logic signed [15:0] i_b [4],
    input  logic signed [31:0] i_value_cur,
    input  logic signed [31:0] i_value_ref,
    input  logic [2:0]         i_channel,
    output t_div_word          o_word
);

    localparam logic signed [32:0] VHI = (33'sd1 <<< (VW_EFF - 1)) - 33'sd1;
    localparam logic signed [32:0] VLO = -VHI - 33'sd1;

    // stage 1: products, squares and the clamped value difference
    logic                r_v1, r_cmd1, r_vsat1;
    logic [2:0]          r_ch1;
    logic [31:0]         r_vd1;
    logic signed [31:0]  r_p [4][4];
    logic [31:0]         r_sq [4];
    logic signed [32:0]  n_diff;
    logic [31:0]         n_vd;
    logic                n_vsat;

    always_comb begin
        n_diff = 33'(i_value_cur) - 33'(i_value_ref);
        n_vsat = 1'b0;
        n_vd   = n_diff[31:0];
        if (n_diff > VHI) begin
            n_vd   = VHI[31:0];
            n_vsat = 1'b1;
        end else if (n_diff < VLO) begin
            n_vd   = VLO[31:0];
            n_vsat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd1  <= i_cmd;
            r_ch1   <= i_channel;
            r_vd1   <= n_vd;
            r_vsat1 <= n_vsat;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p[i][j] <= i_a[i] * i_b[j];
                end
                r_sq[i] <= 32'(i_b[i]) * 32'(i_b[i]);
            end
        end
    end

    // stage 2: Hamilton numerators and squared norm
    logic                r_v2, r_cmd2, r_vsat2;
    logic [2:0]          r_ch2;
    logic [31:0]         r_vd2;
    logic signed [SW-1:0] r_s [4];
    logic [NW-1:0]       r_n2;
    logic signed [SW-1:0] e [4][4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                e[i][j] = SW'(r_p[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd2  <= r_cmd1;
            r_ch2   <= r_ch1;
            r_vd2   <= r_vd1;
            r_vsat2 <= r_vsat1;
            r_s[0]  <=  e[0][0] + e[1][1] + e[2][2] + e[3][3];
            r_s[1]  <= -e[0][1] + e[1][0] - e[2][3] + e[3][2];
            r_s[2]  <= -e[0][2] + e[1][3] + e[2][0] - e[3][1];
            r_s[3]  <= -e[0][3] - e[1][2] + e[2][1] + e[3][0];
            r_n2    <= NW'(r_sq[0]) + NW'(r_sq[1]) + NW'(r_sq[2]) + NW'(r_sq[3]);
        end
    end

    // stage 3: rounding offset, magnitude, early overflow check
    t_div_word           n_w, r_w;
    logic [NW-1:0]       mag;
    logic [RW-1:0]       x;
    logic [RW-1:0]       lim;

    always_comb begin
        n_w         = '0;
        n_w.valid   = r_v2;
        n_w.cmd     = r_cmd2;
        n_w.channel = r_ch2;
        n_w.vdiff   = r_vd2;
        n_w.vsat    = r_vsat2;
        n_w.nz      = (r_n2 != '0);
        n_w.den     = RW'(r_n2) << (QBITS - 1);
        lim         = RW'(r_n2) << QBITS;
        mag         = '0;
        x           = '0;
        for (int i = 0; i < 4; i++) begin
            n_w.neg[i] = r_s[i][SW-1];
            mag        = r_s[i][SW-1] ? NW'(-r_s[i]) : NW'(r_s[i]);
            x          = (RW'(mag) << QF) + RW'(r_n2 >> 1);
            n_w.big[i] = (x >= lim);
            n_w.rem[i] = x;
        end
    end

    // reset clears the valid bit only; the payload loads whenever the pipe advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.valid <= 1'b0;
        end else if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_word = r_w;

endmodule

@@ design/qrr_div_stage.sv @@
// One restoring-divider stage: two quotient bits for each of the four components.
// Depends on qrr_pkg.
module qrr_div_stage import qrr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word     n_w, r_w;
    logic [RW-1:0] rem;

    // remainder stays below twice the shifted divisor, so each step yields one bit
    always_comb begin
        n_w = i_word;
        rem = '0;
        for (int i = 0; i < 4; i++) begin
            rem = i_word.rem[i];
            for (int k = 0; k < 2; k++) begin
                if (rem >= i_word.den) begin
                    rem = rem - i_word.den;
                    n_w.quo[i] = {n_w.quo[i][QBITS-2:0], 1'b1};
                end else begin
                    n_w.quo[i] = {n_w.quo[i][QBITS-2:0], 1'b0};
                end
                rem = rem << 1;
            end
            n_w.rem[i] = rem;
        end
    end

    // reset clears the valid bit only; the payload loads whenever the pipe advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.valid <= 1'b0;
        end else if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_word = r_w;

endmodule

@@ design/quaternion_relative_rotation_unit.sv @@
// Top level: front stages, divider chain and output register.
// Depends on qrr_pkg, qrr_front, qrr_div_stage.
//
//  channel | handshake                  | payload
//  in      | i_in_valid / o_in_ready    | i_cmd, i_a_*, i_b_*, i_value_*, i_channel
//  out     | o_out_valid / i_out_ready  | o_kind, o_q_*, o_value_diff, o_channel_out, o_saturated
//
// One transfer per cycle in and out while the output register is empty or taken; the pipe
// has 3 front stages, 8 divider stages of 2 quotient bits and 1 output stage.
// The divider chain sets the depth. The whole pipe advances together whenever
// the output register is empty or taken; a stall freezes every stage.
// Reset clears the valid bits only.
module quaternion_relative_rotation_unit import qrr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [31:0] i_value_cur,
    input  logic signed [31:0] i_value_ref,
    input  logic [2:0]         i_channel,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic signed [15:0] o_q_w,
    output logic signed [15:0] o_q_x,
    output logic signed [15:0] o_q_y,
    output logic signed [15:0] o_q_z,
    output logic signed [31:0] o_value_diff,
    output logic [2:0]         o_channel_out,
    output logic               o_saturated
);

    logic               en;
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    t_div_word          w [DIV_STAGES+1];

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign a[0] = i_a_w;
    assign a[1] = i_a_x;
    assign a[2] = i_a_y;
    assign a[3] = i_a_z;
    assign b[0] = i_b_w;
    assign b[1] = i_b_x;
    assign b[2] = i_b_y;
    assign b[3] = i_b_z;

    qrr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_cmd       (i_cmd),
        .i_a         (a),
        .i_b         (b),
        .i_value_cur (i_value_cur),
        .i_value_ref (i_value_ref),
        .i_channel   (i_channel),
        .o_word      (w[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        qrr_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w[g]),
            .o_word  (w[g+1])
        );
    end

    // sign, clamp and field selection
    t_div_word          f;
    logic [15:0]        n_q [4];
    logic [3:0]         qsat;
    logic               n_sat;
    logic [31:0]        n_vd;
    logic [2:0]         n_ch;
    logic               r_valid, r_kind, r_sat;
    logic [15:0]        r_q [4];
    logic [31:0]        r_vd;
    logic [2:0]         r_ch;

    assign f = w[DIV_STAGES];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_q[i]  = '0;
            qsat[i] = 1'b0;
            if (f.cmd == CMD_QUAT && f.nz) begin
                if (!f.neg[i]) begin
                    if (f.big[i] || f.quo[i] > 16'd32767) begin
                        n_q[i]  = 16'h7FFF;
                        qsat[i] = 1'b1;
                    end else begin
                        n_q[i] = f.quo[i];
                    end
                end else begin
                    if (f.big[i] || f.quo[i] > 16'd32768) begin
                        n_q[i]  = 16'h8000;
                        qsat[i] = 1'b1;
                    end else begin
                        n_q[i] = -f.quo[i];
                    end
                end
            end
        end
        if (f.cmd == CMD_VALUE) begin
            n_vd  = f.vdiff;
            n_ch  = f.channel;
            n_sat = f.vsat;
        end else begin
            n_vd  = '0;
            n_ch  = '0;
            n_sat = |qsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= f.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= f.cmd;
            r_sat  <= n_sat;
            r_vd   <= n_vd;
            r_ch   <= n_ch;
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= n_q[i];
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_q_w         = r_q[0];
    assign o_q_x         = r_q[1];
    assign o_q_y         = r_q[2];
    assign o_q_z         = r_q[3];
    assign o_value_diff  = r_vd;
    assign o_channel_out = r_ch;
    assign o_saturated   = r_sat;

endmodule

@@ design/qrr_checker.sv @@
// Port-level checks for the quaternion relative rotation unit, bound to the top level.
// Depends on qrr_pkg and quaternion_relative_rotation_unit.
module qrr_checker import qrr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_kind,
    input logic signed [15:0] o_q_w,
    input logic signed [15:0] o_q_x,
    input logic signed [15:0] o_q_y,
    input logic signed [15:0] o_q_z,
    input logic signed [31:0] o_value_diff,
    input logic [2:0]         o_channel_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_q_w) && $stable(o_value_diff))
        else $error("stalled result changed");

    a_value_q_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == CMD_VALUE |->
            o_q_w == 16'sd0 && o_q_x == 16'sd0 && o_q_y == 16'sd0 && o_q_z == 16'sd0)
        else $error("value result carries quaternion data");

    a_quat_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == CMD_QUAT |-> o_value_diff == 32'sd0 && o_channel_out == 3'd0)
        else $error("quaternion result carries value data");

endmodule

bind quaternion_relative_rotation_unit qrr_checker u_qrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_q_w         (o_q_w),
    .o_q_x         (o_q_x),
    .o_q_y         (o_q_y),
    .o_q_z         (o_q_z),
    .o_value_diff  (o_value_diff),
    .o_channel_out (o_channel_out)
);
